FILE: hdl/assert_macros.svh
// assertion macros used by the decoder top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold in the same cycle, checked outside reset
`define B64D_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define B64D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/b64d_pkg.sv
// types and constants of the base64 group decoder
package b64d_pkg;

  localparam logic [31:0] WsWord   = 32'h0a0d_2020;
  localparam logic [31:0] BiasWord = 32'h2b2b_2b2b;
  localparam logic [31:0] SignMask = 32'h8080_8080;
  localparam int unsigned NumLanes = 4;

  // one input word: four characters, char0 lowest
  typedef struct packed {
    logic [7:0] char3;
    logic [7:0] char2;
    logic [7:0] char1;
    logic [7:0] char0;
  } b64d_in_t;

  // one result word
  typedef struct packed {
    logic [7:0] byte_first;
    logic [7:0] byte_second;
    logic [7:0] byte_third;
    logic [1:0] byte_count;
    logic       ended;
  } b64d_out_t;

  // what one lane reports for its character
  typedef struct packed {
    logic [5:0] sextet;
    logic       ok;
  } b64d_lane_t;

  // merge stage result: emit low means the group is skipped
  typedef struct packed {
    logic      emit;
    b64d_out_t res;
  } b64d_merge_t;

endpackage

FILE: hdl/b64d_stream_if.sv
// valid/ready stream channel carrying one payload word
interface b64d_stream_if #(
  parameter type PayloadT = logic
);
  logic    valid;
  logic    ready;
  PayloadT data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/base64_group_decoder.sv
// base64 group decoder top level: four lanes, merge and output register
//
//   channel | dir | word                                  | accepted when
//   --------+-----+---------------------------------------+-------------------
//   in_i    | in  | char0..char3                          | valid && ready
//   out_o   | out | byte_first/second/third, count, ended | valid && ready
//
// one group per cycle while out_o is not stalled; a result appears the cycle after its group is taken
// the lanes and merge are combinational, the output register is the only stage
// a whitespace group (exactly WsWord: two spaces, CR, LF) is taken but leaves the output register empty
// reset clears the output valid flag only
// in_i.ready follows out_o.ready when a result is held, so a stall holds the word
module base64_group_decoder (
  input  logic         clk_i,
  input  logic         rst_ni,
  b64d_stream_if.sink   in_i,
  b64d_stream_if.source out_o
);
  import b64d_pkg::*;
  `include "assert_macros.svh"

  b64d_in_t                  in_word;
  b64d_lane_t [NumLanes-1:0] lanes;
  b64d_merge_t               merged;
  logic                      in_fire;
  logic                      valid_q, valid_d;
  b64d_out_t                 data_q;

  assign in_word = in_i.data;

  // one lane per character
  b64d_lane u_lane0 (.char_i(in_word.char0), .lane_o(lanes[0]));
  b64d_lane u_lane1 (.char_i(in_word.char1), .lane_o(lanes[1]));
  b64d_lane u_lane2 (.char_i(in_word.char2), .lane_o(lanes[2]));
  b64d_lane u_lane3 (.char_i(in_word.char3), .lane_o(lanes[3]));

  b64d_merge u_merge (
    .word_i  (in_word),
    .lanes_i (lanes),
    .merge_o (merged)
  );

  // handshake
  assign in_i.ready = !valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (in_fire) begin
      valid_d = merged.emit;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && merged.emit) begin
      data_q <= merged.res;
    end
  end

  assign out_o.valid = valid_q;
  assign out_o.data  = data_q;

  // checks
  `B64D_ASSERT(a_full_iff_open, clk_i, rst_ni, !out_o.valid || ((out_o.data.byte_count == 2'd3) == !out_o.data.ended), "three bytes must mean not ended")
  `B64D_ASSERT(a_empty_zero, clk_i, rst_ni, !(out_o.valid && out_o.data.byte_count == 2'd0) || (out_o.data.byte_first == 8'd0 && out_o.data.byte_second == 8'd0 && out_o.data.byte_third == 8'd0), "empty result carries nonzero bytes")
  `B64D_ASSERT_NEXT(a_group_gives_word, clk_i, rst_ni, in_fire && merged.emit, out_o.valid, "accepted group lost its result")
  `B64D_ASSERT_NEXT(a_ws_skipped, clk_i, rst_ni, in_fire && !merged.emit, !out_o.valid, "whitespace group produced a result")
endmodule

FILE: hdl/b64d_lane.sv
// one decode lane: maps a character to its 6-bit alphabet value
module b64d_lane (
  input  logic [7:0]          char_i,
  output b64d_pkg::b64d_lane_t lane_o
);
  import b64d_pkg::*;

  // alphabet lookup by range
  always_comb begin
    logic [7:0] val;
    val    = 8'd0;
    lane_o = '0;
    if (char_i >= 8'h41 && char_i <= 8'h5a) begin
      val       = char_i - 8'h41;
      lane_o.ok = 1'b1;
    end else if (char_i >= 8'h61 && char_i <= 8'h7a) begin
      val       = char_i - 8'h61 + 8'd26;
      lane_o.ok = 1'b1;
    end else if (char_i >= 8'h30 && char_i <= 8'h39) begin
      val       = char_i - 8'h30 + 8'd52;
      lane_o.ok = 1'b1;
    end else if (char_i == 8'h2b) begin
      val       = 8'd62;
      lane_o.ok = 1'b1;
    end else if (char_i == 8'h2f) begin
      val       = 8'd63;
      lane_o.ok = 1'b1;
    end
    lane_o.sextet = val[5:0];
  end
endmodule

FILE: hdl/b64d_merge.sv
// merge stage: whitespace skip, range check and byte assembly
module b64d_merge (
  input  b64d_pkg::b64d_in_t                       word_i,
  input  b64d_pkg::b64d_lane_t [b64d_pkg::NumLanes-1:0] lanes_i,
  output b64d_pkg::b64d_merge_t                    merge_o
);
  import b64d_pkg::*;

  logic [31:0] word;
  logic [31:0] diff;
  logic        sign_any;

  // biased subtract over the whole word, borrows included
  assign word     = word_i;
  assign diff     = word - BiasWord;
  assign sign_any = |(diff & SignMask);

  // assemble bytes, stopping at the first bad character; a failed range check over the word gives no bytes
  always_comb begin
    merge_o                 = '0;
    merge_o.emit            = (word != WsWord);
    merge_o.res.ended       = 1'b1;
    if (!sign_any && lanes_i[0].ok && lanes_i[1].ok) begin
      merge_o.res.byte_first = {lanes_i[0].sextet, lanes_i[1].sextet[5:4]};
      merge_o.res.byte_count = 2'd1;
      if (lanes_i[2].ok) begin
        merge_o.res.byte_second = {lanes_i[1].sextet[3:0], lanes_i[2].sextet[5:2]};
        merge_o.res.byte_count  = 2'd2;
        if (lanes_i[3].ok) begin
          merge_o.res.byte_third = {lanes_i[2].sextet[1:0], lanes_i[3].sextet};
          merge_o.res.byte_count = 2'd3;
          merge_o.res.ended      = 1'b0;
        end
      end
    end
  end
endmodule
